[hdl/chte_pkg.sv]
// Package for the chained hash table engine.
// Holds field widths, operation codes, status codes and register indexes.
// No dependencies.
package chte_pkg;

	localparam int KEY_W = 31;
	localparam int VAL_W = 32;
	localparam int ENTRY_W = KEY_W + VAL_W;
	localparam int OP_W = 2;
	localparam int STATUS_W = 3;
	localparam int TOTAL_W = 7;
	localparam int LIMIT_W = 4;
	localparam int CFG_W = 7;

	localparam int DEF_MAX_BUCKETS = 64;
	localparam int DEF_SLOTS = 8;
	localparam int RESET_BUCKETS = 8;
	localparam int RESET_LIMIT = 2;

	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;

	localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
	localparam logic [STATUS_W-1:0] ST_UPDATED = 3'd1;
	localparam logic [STATUS_W-1:0] ST_REMOVED = 3'd2;
	localparam logic [STATUS_W-1:0] ST_FOUND = 3'd3;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;
	localparam logic [STATUS_W-1:0] ST_FULL = 3'd5;

	localparam logic CFG_INITIAL_BUCKETS = 1'b0;
	localparam logic CFG_LOAD_LIMIT = 1'b1;

endpackage

[hdl/chained_hash_table_engine_unit.sv]
// Chained hash table engine, top level.
// Key/value store with bounded buckets and doubling rehash.
// Input transaction: s_tuser carries the operation, s_tdata the key and value.
// Output transaction: one per input; m_tuser carries status and the resized
// flag, m_tdata the found value and the bucket count in use.
// Configuration: cfg_we/cfg_index/cfg_wdata, index 0 initial bucket count
// (writing it empties the table), index 1 load limit. Write only when idle.
// Flow: one item at a time; s_tready is high only in the idle state.
// A lookup, update or remove runs the key through the 31-step bit-serial
// modulo unit and then scans the bucket one slot at a time; the block then
// returns to idle before it accepts the next item. A new insert also appends
// to the bucket, and a remove moves each later slot down one by one. An insert
// that doubles the table first copies every entry of each old bucket into the
// scratch store, then rehashes each copied entry and hashes the new key again.
// Reset empties the table and loads 8 buckets and a load limit of 2; no
// clearing pass is needed. A finished result sits in an output register while
// the receiver stalls; the next item is taken meanwhile, and its result waits
// until the register is free.
module chained_hash_table_engine_unit
	import chte_pkg::*;
#(
	parameter int MAX_BUCKETS = DEF_MAX_BUCKETS,
	parameter int SLOTS_PER_BUCKET = DEF_SLOTS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // key[30:0], value[62:31], zero[63]
	input  logic [1:0]  s_tuser,   // operation[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // found_value[31:0], bucket_total[38:32], zero[39]
	output logic [3:0]  m_tuser,   // status[2:0], resized[3]
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [6:0]  cfg_wdata
);

	localparam int BW = $clog2(MAX_BUCKETS + 1);
	localparam int BIW = $clog2(MAX_BUCKETS);
	localparam int DEPTH = MAX_BUCKETS * SLOTS_PER_BUCKET;
	localparam int AW = $clog2(DEPTH);
	localparam int FW = $clog2(SLOTS_PER_BUCKET + 1);
	localparam int IW = $clog2(DEPTH + 1);
	localparam int PW = BW + LIMIT_W;
	localparam int WW = (PW > IW ? PW : IW) + 1;
	localparam int MW = (BW > CFG_W ? BW : CFG_W) + 1;

	localparam logic [4:0] S_IDLE   = 5'd0;
	localparam logic [4:0] S_START  = 5'd1;
	localparam logic [4:0] S_DIV    = 5'd2;
	localparam logic [4:0] S_FADDR  = 5'd3;
	localparam logic [4:0] S_FGET   = 5'd4;
	localparam logic [4:0] S_SCAN   = 5'd5;
	localparam logic [4:0] S_CMP    = 5'd6;
	localparam logic [4:0] S_ACT    = 5'd7;
	localparam logic [4:0] S_APPEND = 5'd8;
	localparam logic [4:0] S_RMRD   = 5'd9;
	localparam logic [4:0] S_RMWR   = 5'd10;
	localparam logic [4:0] S_RMEND  = 5'd11;
	localparam logic [4:0] S_RES    = 5'd12;
	localparam logic [4:0] S_RHF    = 5'd13;
	localparam logic [4:0] S_RHFG   = 5'd14;
	localparam logic [4:0] S_RHE    = 5'd15;
	localparam logic [4:0] S_RHCP   = 5'd16;
	localparam logic [4:0] S_RHCLR  = 5'd17;
	localparam logic [4:0] S_RHSR   = 5'd18;
	localparam logic [4:0] S_RHSK   = 5'd19;
	localparam logic [4:0] S_RHSD   = 5'd20;
	localparam logic [4:0] S_RHSF   = 5'd21;
	localparam logic [4:0] S_RHSG   = 5'd22;

	function automatic logic [BW-1:0] clamp_buckets(input logic [CFG_W-1:0] v);
		logic [BW-1:0] r;
		if (v == '0) begin
			r = BW'(1);
		end else if (MW'(v) > MW'(MAX_BUCKETS)) begin
			r = BW'(MAX_BUCKETS);
		end else begin
			r = BW'(v);
		end
		return r;
	endfunction

	logic [4:0]          state_q;
	logic [OP_W-1:0]     op_q;
	logic [KEY_W-1:0]    key_q;
	logic [VAL_W-1:0]    val_q;
	logic [BIW-1:0]      bkt_q;
	logic [FW-1:0]       fill_q;
	logic [FW-1:0]       slot_q;
	logic                hit_q;
	logic                post_q;
	logic                rsz_q;
	logic [VAL_W-1:0]    found_q;
	logic [STATUS_W-1:0] res_stat_q;
	logic [BW-1:0]       bcnt_q;
	logic [IW-1:0]       item_q;
	logic [LIMIT_W-1:0]  llim_q;
	logic [BW-1:0]       rb_q;
	logic [IW-1:0]       cnt_q;
	logic [IW-1:0]       ix_q;
	logic [ENTRY_W-1:0]  sk_q;
	logic [MAX_BUCKETS-1:0] fvld_q;
	logic                fvld_s1;
	logic                out_v_q;
	logic [STATUS_W-1:0] out_stat_q;
	logic [VAL_W-1:0]    out_val_q;
	logic                out_rsz_q;
	logic [TOTAL_W-1:0]  out_tot_q;

	logic                div_start;
	logic                div_done;
	logic [KEY_W-1:0]    div_num;
	logic [BW-1:0]       div_rem;

	logic [BIW-1:0]      mul_bkt;
	logic [FW-1:0]       off;
	logic [AW-1:0]       e_addr;
	logic                e_we;
	logic [ENTRY_W-1:0]  e_wdata;
	logic [ENTRY_W-1:0]  e_rdata;
	logic                s_we;
	logic [ENTRY_W-1:0]  s_rdata;
	logic [BIW-1:0]      f_raddr;
	logic                f_we;
	logic [FW-1:0]       f_wdata;
	logic [FW-1:0]       f_rdata;
	logic [FW-1:0]       fv;
	logic [LIMIT_W-1:0]  lim;
	logic                load_hit;
	logic                can_double;
	logic                out_free;

	// Shared modulo unit serves both the item's key and every rehashed key.
	assign div_start = (state_q == S_START) || (state_q == S_RHSK);
	assign div_num = (state_q == S_RHSK) ? s_rdata[ENTRY_W-1:VAL_W] : key_q;

	chte_moddiv #(.BW(BW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_num),
		.divisor  (bcnt_q),
		.done     (div_done),
		.rem      (div_rem)
	);

	assign fv = fvld_s1 ? f_rdata : '0;
	assign lim = (llim_q == '0) ? LIMIT_W'(1) : llim_q;
	assign load_hit = WW'(item_q) >= WW'(PW'(lim) * PW'(bcnt_q));
	assign can_double = (MW'(bcnt_q) << 1) <= MW'(MAX_BUCKETS);
	assign out_free = !out_v_q || m_tready;

	always_comb begin
		mul_bkt = (state_q == S_RHE) ? rb_q[BIW-1:0] : bkt_q;
		case (state_q)
			S_APPEND: off = fill_q;
			S_RHSG:   off = fv;
			S_RMRD:   off = slot_q + 1'b1;
			default:  off = slot_q;
		endcase
		e_addr = AW'(AW'(mul_bkt) * AW'(SLOTS_PER_BUCKET)) + AW'(off);
	end

	always_comb begin
		e_we = 1'b0;
		e_wdata = {key_q, val_q};
		case (state_q)
			S_ACT:    e_we = (op_q == OP_INSERT) && hit_q;
			S_APPEND: e_we = fill_q < FW'(SLOTS_PER_BUCKET);
			S_RMWR: begin
				e_we = 1'b1;
				e_wdata = e_rdata;
			end
			S_RHSG: begin
				e_we = fv < FW'(SLOTS_PER_BUCKET);
				e_wdata = sk_q;
			end
			default: e_we = 1'b0;
		endcase
	end

	always_comb begin
		f_we = 1'b0;
		f_wdata = fill_q + 1'b1;
		case (state_q)
			S_APPEND: f_we = fill_q < FW'(SLOTS_PER_BUCKET);
			S_RMEND: begin
				f_we = 1'b1;
				f_wdata = fill_q - 1'b1;
			end
			S_RHSG: begin
				f_we = fv < FW'(SLOTS_PER_BUCKET);
				f_wdata = fv + 1'b1;
			end
			default: f_we = 1'b0;
		endcase
	end

	assign f_raddr = (state_q == S_RHF) ? rb_q[BIW-1:0] : bkt_q;
	assign s_we = (state_q == S_RHCP);

	chte_ram #(.DEPTH(DEPTH), .WIDTH(ENTRY_W)) u_entry (
		.clk   (clk),
		.we    (e_we),
		.waddr (e_addr),
		.wdata (e_wdata),
		.raddr (e_addr),
		.rdata (e_rdata)
	);

	chte_ram #(.DEPTH(DEPTH), .WIDTH(ENTRY_W)) u_scratch (
		.clk   (clk),
		.we    (s_we),
		.waddr (cnt_q[AW-1:0]),
		.wdata (e_rdata),
		.raddr (ix_q[AW-1:0]),
		.rdata (s_rdata)
	);

	chte_ram #(.DEPTH(MAX_BUCKETS), .WIDTH(FW)) u_fill (
		.clk   (clk),
		.we    (f_we),
		.waddr (bkt_q),
		.wdata (f_wdata),
		.raddr (f_raddr),
		.rdata (f_rdata)
	);

	always_ff @(posedge clk) begin
		fvld_s1 <= fvld_q[f_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			bcnt_q <= clamp_buckets(CFG_W'(RESET_BUCKETS));
			llim_q <= LIMIT_W'(RESET_LIMIT);
			item_q <= '0;
			fvld_q <= '0;
			out_v_q <= 1'b0;
			post_q <= 1'b0;
			rsz_q <= 1'b0;
			hit_q <= 1'b0;
		end else begin
			if (m_tready) begin
				out_v_q <= 1'b0;
			end
			if (cfg_we) begin
				if (cfg_index == CFG_INITIAL_BUCKETS) begin
					bcnt_q <= clamp_buckets(cfg_wdata);
					item_q <= '0;
					fvld_q <= '0;
				end else begin
					llim_q <= cfg_wdata[LIMIT_W-1:0];
				end
			end
			if (f_we) begin
				fvld_q[bkt_q] <= 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						post_q <= 1'b0;
						rsz_q <= 1'b0;
						state_q <= S_START;
					end
				end
				S_START: state_q <= S_DIV;
				S_DIV: begin
					if (div_done) begin
						state_q <= S_FADDR;
					end
				end
				S_FADDR: state_q <= S_FGET;
				S_FGET: begin
					hit_q <= 1'b0;
					state_q <= post_q ? S_APPEND : S_SCAN;
				end
				S_SCAN: state_q <= (slot_q < fill_q) ? S_CMP : S_ACT;
				S_CMP: begin
					if (e_rdata[ENTRY_W-1:VAL_W] == key_q) begin
						hit_q <= 1'b1;
						state_q <= S_ACT;
					end else begin
						state_q <= S_SCAN;
					end
				end
				S_ACT: begin
					if (op_q == OP_INSERT) begin
						if (hit_q) begin
							state_q <= S_RES;
						end else if (load_hit && can_double) begin
							rsz_q <= 1'b1;
							state_q <= S_RHF;
						end else begin
							state_q <= S_APPEND;
						end
					end else if (op_q == OP_REMOVE && hit_q) begin
						state_q <= S_RMRD;
					end else begin
						state_q <= S_RES;
					end
				end
				S_APPEND: begin
					if (fill_q < FW'(SLOTS_PER_BUCKET)) begin
						item_q <= item_q + 1'b1;
					end
					state_q <= S_RES;
				end
				S_RMRD: state_q <= (slot_q + 1'b1 < fill_q) ? S_RMWR : S_RMEND;
				S_RMWR: state_q <= S_RMRD;
				S_RMEND: begin
					item_q <= item_q - 1'b1;
					state_q <= S_RES;
				end
				S_RES: begin
					if (out_free) begin
						out_v_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_RHF: state_q <= (rb_q < bcnt_q) ? S_RHFG : S_RHCLR;
				S_RHFG: state_q <= S_RHE;
				S_RHE: state_q <= (slot_q < fill_q) ? S_RHCP : S_RHF;
				S_RHCP: state_q <= S_RHE;
				S_RHCLR: begin
					fvld_q <= '0;
					bcnt_q <= BW'(bcnt_q << 1);
					item_q <= '0;
					state_q <= S_RHSR;
				end
				S_RHSR: begin
					if (ix_q < cnt_q) begin
						state_q <= S_RHSK;
					end else begin
						post_q <= 1'b1;
						state_q <= S_START;
					end
				end
				S_RHSK: state_q <= S_RHSD;
				S_RHSD: begin
					if (div_done) begin
						state_q <= S_RHSF;
					end
				end
				S_RHSF: state_q <= S_RHSG;
				S_RHSG: begin
					if (fv < FW'(SLOTS_PER_BUCKET)) begin
						item_q <= item_q + 1'b1;
					end
					state_q <= S_RHSR;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers; no reset needed.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				op_q <= s_tuser;
				key_q <= s_tdata[KEY_W-1:0];
				val_q <= s_tdata[KEY_W+VAL_W-1:KEY_W];
				found_q <= '0;
			end
			S_DIV: if (div_done) bkt_q <= div_rem[BIW-1:0];
			S_FGET: begin
				fill_q <= fv;
				slot_q <= '0;
			end
			S_CMP: begin
				if (e_rdata[ENTRY_W-1:VAL_W] == key_q) begin
					found_q <= e_rdata[VAL_W-1:0];
				end else begin
					slot_q <= slot_q + 1'b1;
				end
			end
			S_ACT: begin
				rb_q <= '0;
				cnt_q <= '0;
				if (op_q == OP_INSERT) begin
					res_stat_q <= ST_UPDATED;
				end else if (op_q == OP_REMOVE) begin
					res_stat_q <= hit_q ? ST_REMOVED : ST_NOT_FOUND;
				end else begin
					res_stat_q <= hit_q ? ST_FOUND : ST_NOT_FOUND;
				end
				if (op_q == OP_INSERT || op_q == OP_REMOVE) begin
					found_q <= '0;
				end
			end
			S_APPEND: begin
				res_stat_q <= (fill_q < FW'(SLOTS_PER_BUCKET)) ? ST_INSERTED : ST_FULL;
			end
			S_RMWR: slot_q <= slot_q + 1'b1;
			S_RES: begin
				if (out_free) begin
					out_stat_q <= res_stat_q;
					out_val_q <= found_q;
					out_rsz_q <= rsz_q;
					out_tot_q <= TOTAL_W'(bcnt_q);
				end
			end
			S_RHF: if (rb_q < bcnt_q) slot_q <= '0;
			S_RHFG: fill_q <= fv;
			S_RHE: if (!(slot_q < fill_q)) rb_q <= rb_q + 1'b1;
			S_RHCP: begin
				cnt_q <= cnt_q + 1'b1;
				slot_q <= slot_q + 1'b1;
			end
			S_RHCLR: ix_q <= '0;
			S_RHSK: sk_q <= s_rdata;
			S_RHSD: if (div_done) bkt_q <= div_rem[BIW-1:0];
			S_RHSG: ix_q <= ix_q + 1'b1;
			default: ;
		endcase
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_v_q;
	assign m_tdata = {1'b0, out_tot_q, out_val_q};
	assign m_tuser = {out_rsz_q, out_stat_q};

`ifndef SYNTHESIS
	a_bcnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(bcnt_q != '0) && (MW'(bcnt_q) <= MW'(MAX_BUCKETS)))
		else $error("bucket count out of range");
	a_item_bound: assert property (@(posedge clk) disable iff (!arst_n)
		IW'(item_q) <= IW'(DEPTH))
		else $error("item count beyond store depth");
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (fill_q <= FW'(SLOTS_PER_BUCKET)))
		else $error("bucket fill beyond slot count");
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == S_RES))
		else $error("result presented outside result state");
	a_double_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RHCLR) |-> can_double)
		else $error("table doubled past maximum");
`endif

endmodule

[hdl/chte_ram.sv]
// Simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module chte_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

[hdl/chte_moddiv.sv]
// Iterative remainder unit: key modulo bucket count, one quotient bit a cycle.
// Depends on chte_pkg.
module chte_moddiv
	import chte_pkg::*;
#(
	parameter int BW = 7
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [KEY_W-1:0] dividend,
	input  logic [BW-1:0]    divisor,
	output logic             done,
	output logic [BW-1:0]    rem
);

	localparam int CW = $clog2(KEY_W + 1);

	logic [KEY_W-1:0] num_q;
	logic [BW-1:0]    rem_q;
	logic [BW-1:0]    div_q;
	logic [CW-1:0]    cnt_q;
	logic             run_q;
	logic             done_q;
	logic [BW:0]      trial;
	logic [BW-1:0]    rem_nx;

	always_comb begin
		trial = {rem_q, num_q[KEY_W-1]};
		if (trial >= {1'b0, div_q}) begin
			rem_nx = BW'(trial - {1'b0, div_q});
		end else begin
			rem_nx = trial[BW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CW'(KEY_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (run_q) begin
			num_q <= {num_q[KEY_W-2:0], 1'b0};
			rem_q <= rem_nx;
		end
	end

	assign done = done_q;
	assign rem = rem_q;

endmodule

[tb/sv/chte_table_checker.sv]
// Checker for the chained hash table engine: mirrors the table contents,
// predicts one reply per accepted request and compares it with the output.
// Depends on chte_pkg for widths and codes.
module chte_table_checker
	import chte_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [63:0] s_tdata,
	input  logic [1:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [39:0] m_tdata,
	input  logic [3:0]  m_tuser,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [6:0]  cfg_wdata,
	output int          fail_count,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NB = DEF_MAX_BUCKETS;
	localparam int NS = DEF_SLOTS;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [VAL_W-1:0]    found_value;
		logic                resized;
		logic [TOTAL_W-1:0]  bucket_total;
	} reply_t;

	reply_t expected_replies[$];

	logic [KEY_W-1:0] slot_key[NB][NS];
	logic [VAL_W-1:0] slot_val[NB][NS];
	int unsigned      fill[NB];
	logic [KEY_W-1:0] old_key[NB][NS];
	logic [VAL_W-1:0] old_val[NB][NS];
	int unsigned      old_fill[NB];
	int unsigned      buckets;
	int unsigned      items;
	logic [CFG_W-1:0]   initial_reg;
	logic [LIMIT_W-1:0] limit_reg;

	function automatic int unsigned clamp_buckets(logic [CFG_W-1:0] v);
		if (v == 0) return 1;
		if (v > NB) return NB;
		return v;
	endfunction

	task automatic empty_table();
		for (int b = 0; b < NB; b++) fill[b] = 0;
		buckets = clamp_buckets(initial_reg);
		items = 0;
	endtask

	task automatic append_entry(int unsigned b, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
		slot_key[b][fill[b]] = k;
		slot_val[b][fill[b]] = v;
		fill[b]++;
		items++;
	endtask

	// Rehash in order of old bucket, then slot.
	task automatic double_table();
		int unsigned old_m;
		int unsigned nb;
		old_m = buckets;
		old_key = slot_key;
		old_val = slot_val;
		old_fill = fill;
		for (int b = 0; b < NB; b++) fill[b] = 0;
		buckets = old_m * 2;
		items = 0;
		for (int b = 0; b < old_m; b++)
			for (int s = 0; s < old_fill[b] && s < NS; s++) begin
				nb = old_key[b][s] % buckets;
				if (fill[nb] < NS) append_entry(nb, old_key[b][s], old_val[b][s]);
			end
	endtask

	task automatic model_table_op(logic [OP_W-1:0] op, logic [KEY_W-1:0] k,
			logic [VAL_W-1:0] v);
		reply_t r;
		int unsigned b;
		int slot;
		int unsigned lim;
		r = '0;
		b = k % buckets;
		slot = -1;
		for (int s = 0; s < fill[b] && s < NS; s++)
			if (slot < 0 && slot_key[b][s] == k) slot = s;
		if (op == OP_INSERT) begin
			if (slot >= 0) begin
				slot_val[b][slot] = v;
				r.status = ST_UPDATED;
			end else begin
				lim = (limit_reg == 0) ? 1 : limit_reg;
				if (items / buckets >= lim && buckets * 2 <= NB) begin
					double_table();
					r.resized = 1'b1;
					b = k % buckets;
				end
				if (fill[b] < NS) begin
					append_entry(b, k, v);
					r.status = ST_INSERTED;
				end else begin
					r.status = ST_FULL;
				end
			end
		end else if (op == OP_REMOVE) begin
			if (slot >= 0) begin
				// close the gap: later slots move down one
				for (int s = slot; s + 1 < fill[b]; s++) begin
					slot_key[b][s] = slot_key[b][s+1];
					slot_val[b][s] = slot_val[b][s+1];
				end
				fill[b]--;
				items--;
				r.status = ST_REMOVED;
			end else begin
				r.status = ST_NOT_FOUND;
			end
		end else begin
			if (slot >= 0) begin
				r.found_value = slot_val[b][slot];
				r.status = ST_FOUND;
			end else begin
				r.status = ST_NOT_FOUND;
			end
		end
		r.bucket_total = TOTAL_W'(buckets);
		expected_replies = {expected_replies, r};
	endtask

	always @(posedge clk or negedge arst_n) begin
		reply_t exp_r;
		reply_t got;
		if (!arst_n) begin
			initial_reg = CFG_W'(RESET_BUCKETS);
			limit_reg = LIMIT_W'(RESET_LIMIT);
			empty_table();
			expected_replies.delete();
			fail_count <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_INITIAL_BUCKETS) begin
					initial_reg = cfg_wdata;
					empty_table();
				end else begin
					limit_reg = cfg_wdata[LIMIT_W-1:0];
				end
			end
			if (s_tvalid && s_tready)
				model_table_op(s_tuser, s_tdata[30:0], s_tdata[62:31]);
			if (m_tvalid && m_tready) begin
				got.status = m_tuser[2:0];
				got.resized = m_tuser[3];
				got.found_value = m_tdata[31:0];
				got.bucket_total = m_tdata[38:32];
				if (expected_replies.size() == 0) begin
					$display("%0t: reply with nothing expected: %p", $time, got);
					fail_count <= fail_count + 1;
				end else begin
					exp_r = expected_replies.pop_front();
					if (got !== exp_r) begin
						$display("%0t: mismatch expected %p actual %p", $time, exp_r, got);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
		pending <= expected_replies.size();
	end

endmodule

[tb/sv/chained_hash_table_engine_unit_test.sv]
// Testbench top for chained_hash_table_engine_unit: clock, reset, stimulus
// and verdict. Prediction and checking live in chte_table_checker.
// Depends on chte_pkg and the block's RTL.
module chained_hash_table_engine_unit_test;
	import chte_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;
	localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int PHASES = 7;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;
	logic [3:0]  m_tuser;
	logic        cfg_we;
	logic        cfg_index;
	logic [6:0]  cfg_wdata;
	int          fail_count;
	int          pending;
	int          cycles;
	logic        hold_req;
	int          burst_left;
	logic [KEY_W-1:0] key_pool[256];

	chained_hash_table_engine_unit i_dut (.*);

	chte_table_checker i_checker (.*);

	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Receiver: stretches of steady, random or sparse ready, plus one long hold.
	initial begin
		int seg;
		int mode;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			seg = $urandom_range(20, 200);
			mode = $urandom_range(0, 2);
			for (int i = 0; i < seg; i++) begin
				@(posedge clk);
				if (hold_req) begin
					m_tready <= 1'b0;
					repeat (800) @(posedge clk);
					hold_req = 1'b0;
				end else begin
					case (mode)
						0: m_tready <= 1'b1;
						1: m_tready <= 1'($urandom_range(0, 1));
						default: m_tready <= ($urandom_range(0, 3) == 0);
					endcase
				end
			end
		end
	end

	// Present one item, hold it until accepted; valid drops only in burst gaps.
	task automatic send_item(logic [OP_W-1:0] op, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {1'b0, v, k};
		@(negedge clk);
		while (!s_tready) @(negedge clk);
		@(posedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [6:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(logic [6:0] nbuckets, logic [3:0] limit);
		drain();
		write_reg(CFG_LOAD_LIMIT, {3'b0, limit});
		write_reg(CFG_INITIAL_BUCKETS, nbuckets);
	endtask

	initial begin
		int n_items;
		int pool_n;
		int mix;
		int pick;
		logic [OP_W-1:0] op;
		logic [KEY_W-1:0] k;
		logic [6:0] nb;
		logic [3:0] lim;
		cycles = 0;
		hold_req = 1'b0;
		burst_left = 0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		cfg_we = 1'b0;
		cfg_index = 1'b0;
		cfg_wdata = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: field extremes, every operation, slot shift on remove.
		send_item(OP_INSERT, '0, 32'h8000_0000);
		send_item(OP_INSERT, 31'h7fff_ffff, 32'h7fff_ffff);
		send_item(OP_LOOKUP, '0, '0);
		send_item(OP_LOOKUP, 31'h7fff_ffff, 32'hffff_ffff);
		send_item(OP_INSERT, '0, 32'hffff_ffff);
		send_item(OP_SPARE, '0, '0);
		send_item(OP_REMOVE, 31'h7fff_ffff, '0);
		send_item(OP_REMOVE, 31'h7fff_ffff, '0);
		send_item(OP_LOOKUP, 31'h7fff_ffff, '0);
		send_item(OP_INSERT, 31'd8, 32'd1);
		send_item(OP_INSERT, 31'd16, 32'd2);
		send_item(OP_INSERT, 31'd24, 32'd3);
		send_item(OP_REMOVE, 31'd16, '0);
		send_item(OP_LOOKUP, 31'd24, '0);

		// Full bucket at the bucket maximum.
		configure(7'd64, 4'd8);
		for (int i = 0; i < 9; i++) send_item(OP_INSERT, 31'(i * 64), $urandom);

		// Doubling right before a rejected insert.
		configure(7'd1, 4'd8);
		for (int i = 0; i < 9; i++) send_item(OP_INSERT, 31'(i * 2), $urandom);

		// Random phases, extreme settings first.
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: begin nb = 7'd127; lim = 4'd15; end
				1: begin nb = 7'd0; lim = 4'd0; end
				2: begin nb = 7'd64; lim = 4'd1; end
				3: begin nb = 7'd1; lim = 4'd1; end
				default: begin
					nb = 7'($urandom_range(0, 127));
					lim = 4'($urandom_range(0, 15));
				end
			endcase
			configure(nb, lim);
			pool_n = (ph == 2) ? 256 : $urandom_range(16, 256);
			for (int i = 0; i < 256; i++)
				key_pool[i] = (i % 2 == 0) ? 31'($urandom) : 31'($urandom << 6);
			n_items = 250;
			for (int i = 0; i < n_items; i++) begin
				if (ph == 3 && i == 100) hold_req = 1'b1;
				mix = $urandom_range(0, 99);
				if (ph == 2 && i < 150) op = OP_INSERT;
				else if (mix < 50) op = OP_INSERT;
				else if (mix < 70) op = OP_REMOVE;
				else if (mix < 95) op = OP_LOOKUP;
				else op = OP_SPARE;
				pick = $urandom_range(0, pool_n - 1);
				k = ($urandom_range(0, 9) == 0) ? 31'($urandom) : key_pool[pick];
				send_item(op, k, $urandom);
			end
		end

		drain();
		repeat (100) @(posedge clk);
		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

[filelist.f]
hdl/chte_pkg.sv
hdl/chte_ram.sv
hdl/chte_moddiv.sv
hdl/chained_hash_table_engine_unit.sv
tb/sv/chte_table_checker.sv
tb/sv/chained_hash_table_engine_unit_test.sv
